// ===== design/base64_stream_codec_macros.svh =====
// assertion macros shared by the codec modules
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

`ifndef SYNTH
`define B64SC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define B64SC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define B64SC_ASSERT(lbl, prop, msg)
`define B64SC_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/b64sc_pkg.sv =====
`default_nettype none

package b64sc_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // position inside a 3-byte / 4-char group
  localparam logic [1:0] GRP_P0 = 2'd0;
  localparam logic [1:0] GRP_P1 = 2'd1;
  localparam logic [1:0] GRP_P2 = 2'd2;
  localparam logic [1:0] GRP_P3 = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3d;
  localparam logic [7:0] BAD_CODE = 8'hff;

  localparam int unsigned SLOTS = 4;

  // one queued command: up to four results from one input item
  typedef struct packed {
    logic [SLOTS-1:0][7:0] vals;
    logic [1:0]            cnt_m1;
    logic                  has_data;
    logic                  eor;
    logic                  bad;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic [7:0] enc_char(input logic [5:0] code);
    logic [7:0] x;
    x = {2'b00, code};
    if (code < 6'd26) begin
      enc_char = x + 8'h41;          // 'A'
    end else if (code < 6'd52) begin
      enc_char = x + 8'd71;          // 'a' - 26
    end else if (code < 6'd62) begin
      enc_char = x - 8'd4;           // '0' - 52
    end else if (code == 6'd62) begin
      enc_char = 8'h2b;              // '+'
    end else begin
      enc_char = 8'h2f;              // '/'
    end
  endfunction

  function automatic logic [7:0] dec_sixbit(input logic [7:0] ch);
    case (ch) inside
      [8'h41:8'h5a]: dec_sixbit = ch - 8'h41;
      [8'h61:8'h7a]: dec_sixbit = ch - 8'd71;
      [8'h30:8'h39]: dec_sixbit = ch + 8'd4;
      8'h2b:         dec_sixbit = 8'd62;
      8'h2f:         dec_sixbit = 8'd63;
      default:       dec_sixbit = BAD_CODE;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/b64sc_front.sv =====
`default_nettype none

module b64sc_front import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_value_i,
  input  wire logic       last_item_i,
  input  wire q_status_t  q_status_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

`include "base64_stream_codec_macros.svh"

  logic       dir_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] carry_q, carry_d;
  logic       pad_q, pad_d;
  logic       accept;
  logic       has_out;
  logic       cur_bad;
  logic [7:0] code;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    pad_d   = pad_q;
    cmd_o   = '0;
    cmd_o.has_data = 1'b1;
    has_out = 1'b0;
    cur_bad = 1'b0;
    code    = dec_sixbit(in_value_i);

    if (dir_q == DIR_ENCODE) begin
      has_out = 1'b1;
      case (phase_q)
        GRP_P1: begin
          cmd_o.vals[0] = enc_char({carry_q[1:0], in_value_i[7:4]});
          carry_d = {4'b0000, in_value_i[3:0]};
          phase_d = GRP_P2;
          if (last_item_i) begin
            cmd_o.vals[1] = enc_char({in_value_i[3:0], 2'b00});
            cmd_o.vals[2] = PAD_CHAR;
            cmd_o.cnt_m1  = 2'd2;
          end
        end
        GRP_P2: begin
          cmd_o.vals[0] = enc_char({carry_q[3:0], in_value_i[7:6]});
          cmd_o.vals[1] = enc_char(in_value_i[5:0]);
          cmd_o.cnt_m1  = 2'd1;
          carry_d = '0;
          phase_d = GRP_P0;
        end
        default: begin
          // phase three cannot occur here and acts as the group start
          cmd_o.vals[0] = enc_char(in_value_i[7:2]);
          carry_d = {6'b000000, in_value_i[1:0]};
          phase_d = GRP_P1;
          if (last_item_i) begin
            cmd_o.vals[1] = enc_char({in_value_i[1:0], 4'b0000});
            cmd_o.vals[2] = PAD_CHAR;
            cmd_o.vals[3] = PAD_CHAR;
            cmd_o.cnt_m1  = 2'd3;
          end
        end
      endcase
    end else if (!pad_q) begin
      if (in_value_i == PAD_CHAR) begin
        pad_d = 1'b1;
      end else begin
        cur_bad   = (code == BAD_CODE);
        cmd_o.bad = cur_bad || (carry_q == BAD_CODE);
        carry_d   = code;
        case (phase_q)
          GRP_P0: begin
            phase_d = GRP_P1;
          end
          GRP_P1: begin
            has_out = 1'b1;
            cmd_o.vals[0] = {carry_q[5:0], code[5:4]};
            phase_d = GRP_P2;
          end
          GRP_P2: begin
            has_out = 1'b1;
            cmd_o.vals[0] = {carry_q[3:0], code[5:2]};
            phase_d = GRP_P3;
          end
          default: begin
            has_out = 1'b1;
            cmd_o.vals[0] = {carry_q[1:0], 6'b000000} | code;
            carry_d = '0;
            phase_d = GRP_P0;
          end
        endcase
      end
    end

    if (last_item_i) begin
      if (!has_out) begin
        // bare end marker
        cmd_o.has_data = 1'b0;
        cmd_o.bad      = cur_bad;
        cmd_o.cnt_m1   = 2'd0;
        cmd_o.vals     = '0;
      end
      cmd_o.eor = 1'b1;
      phase_d = GRP_P0;
      carry_d = '0;
      pad_d   = 1'b0;
    end
  end

  assign push_o = accept && (has_out || last_item_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_ENCODE;
      phase_q <= GRP_P0;
      carry_q <= '0;
      pad_q   <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q   <= cfg_wdata_i;
      phase_q <= GRP_P0;
      carry_q <= '0;
      pad_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      pad_q   <= pad_d;
    end
  end

  `B64SC_ASSERT(fr_dec_single_a, push_o && dir_q == DIR_DECODE |-> cmd_o.cnt_m1 == 2'd0, "decode command carries more than one result")
  `B64SC_ASSERT(fr_last_clears_a, accept && last_item_i && !cfg_we_i |=> phase_q == GRP_P0 && !pad_q, "state not cleared after last item")

endmodule

`default_nettype wire

// ===== design/b64sc_queue.sv =====
`default_nettype none

module b64sc_queue import b64sc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output q_status_t status_o
);

`include "base64_stream_codec_macros.svh"

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign cmd_o           = mem_q[rd_ptr_q];
  assign status_o.valid  = (count_q != 2'd0);
  assign status_o.full   = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  `B64SC_NEVER(q_overflow_a, push_i && status_o.full, "push into full queue")
  `B64SC_NEVER(q_underflow_a, pop_i && !status_o.valid, "pop from empty queue")

endmodule

`default_nettype wire

// ===== design/b64sc_back.sv =====
`default_nettype none

module b64sc_back import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire q_status_t  q_status_i,
  input  wire cmd_t       q_cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_value_o,
  output logic            has_data_o,
  output logic            end_of_run_o,
  output logic            bad_char_o
);

`include "base64_stream_codec_macros.svh"

  cmd_t       cmd_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_value_q;
  logic       has_data_q;
  logic       eor_q;
  logic       bad_q;
  logic       slot_free;
  logic       emit;
  logic       fin;
  logic       load;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = busy_q && slot_free;
  assign fin       = emit && (idx_q == cmd_q.cnt_m1);
  assign load      = q_status_i.valid && (!busy_q || fin);
  assign pop_o     = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_cmd_i;
    end
    if (emit) begin
      out_value_q <= cmd_q.vals[idx_q];
      has_data_q  <= cmd_q.has_data;
      eor_q       <= cmd_q.eor && fin;
      bad_q       <= cmd_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else begin
        if (fin) begin
          busy_q <= 1'b0;
        end
        if (emit) begin
          idx_q <= idx_q + 2'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign has_data_o   = has_data_q;
  assign end_of_run_o = eor_q;
  assign bad_char_o   = bad_q;

  `B64SC_ASSERT(bk_idx_range_a, busy_q |-> idx_q <= cmd_q.cnt_m1, "result index past command count")
  `B64SC_ASSERT(bk_stall_hold_a, busy_q && out_valid_q && !out_ready_i |=> $stable(idx_q), "index moved while output stalled")

endmodule

`default_nettype wire

// ===== design/base64_stream_codec.sv =====
`default_nettype none

// Base64 codec (standard alphabet, '=' padding) over a byte stream. cfg_we_i writes
// the direction (0 encode, 1 decode) and restarts the message; write it only when the
// block is idle. The front stage takes one item per cycle while its two-entry command
// queue has room and turns it into up to four results; the back stage drains them
// through the output register at one result per cycle while the receiver is ready.
// An encoded byte therefore yields one to four results (four bytes' worth of text per
// three bytes, up to four at the end of a message), a decoded character at most one,
// so the sustained rate is set by the one-result-per-cycle back stage. Results pass the
// command queue, back-stage command register and output register. Items with no result
// (first character of a decode group, padding) are not queued unless they end a message.
module base64_stream_codec import b64sc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_value_i,
  input  wire logic       last_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_value_o,
  output logic            has_data_o,
  output logic            end_of_run_o,
  output logic            bad_char_o
);

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;

  b64sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_value_i  (in_value_i),
    .last_item_i (last_item_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  b64sc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  b64sc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_cmd_i      (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .has_data_o   (has_data_o),
    .end_of_run_o (end_of_run_o),
    .bad_char_o   (bad_char_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_base64_stream_codec.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_codec;
  import b64sc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 24;
  localparam int NUM_PHASES    = 13;
  localparam int SQUEEZE_PHASE = 6;

  typedef struct {
    logic [7:0] value;
    logic       has_data;
    logic       end_of_run;
    logic       bad_char;
  } codec_result_t;

  typedef logic [7:0] byte_q_t[$];

  // tracks the codec state and the results still owed by the block
  class codec_scoreboard;
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic          dir;
    logic [1:0]    group_pos;
    logic [7:0]    held;
    logic          pad_seen;
    codec_result_t expected_q[$];
    codec_result_t step_res[4];
    int            step_n;
    int            errors;

    function void restart(logic d);
      dir       = d;
      group_pos = GRP_P0;
      held      = 8'h00;
      pad_seen  = 1'b0;
    endfunction

    function logic [7:0] code_of(logic [7:0] ch);
      for (int i = 0; i < 64; i++) begin
        if (alphabet[i] == ch) return 8'(i);
      end
      return BAD_CODE;
    endfunction

    function void emit(logic [7:0] val, logic has, logic bad);
      step_res[step_n] = '{val, has, 1'b0, bad};
      step_n++;
    endfunction

    function void emit_char(logic [5:0] code);
      emit(alphabet[code], 1'b1, 1'b0);
    endfunction

    function void note_item(logic [7:0] v, logic last);
      logic [7:0] c;
      logic       bad_now;
      logic       carried_bad;
      step_n  = 0;
      bad_now = 1'b0;
      if (dir == DIR_ENCODE) begin
        case (group_pos)
          GRP_P1: begin
            emit_char({held[1:0], v[7:4]});
            held      = {4'h0, v[3:0]};
            group_pos = GRP_P2;
          end
          GRP_P2: begin
            emit_char({held[3:0], v[7:6]});
            emit_char(v[5:0]);
            held      = 8'h00;
            group_pos = GRP_P0;
          end
          default: begin
            emit_char(v[7:2]);
            held      = {6'h00, v[1:0]};
            group_pos = GRP_P1;
          end
        endcase
        if (last && group_pos == GRP_P1) begin
          emit_char({held[1:0], 4'h0});
          emit(PAD_CHAR, 1'b1, 1'b0);
          emit(PAD_CHAR, 1'b1, 1'b0);
        end else if (last && group_pos == GRP_P2) begin
          emit_char({held[3:0], 2'b00});
          emit(PAD_CHAR, 1'b1, 1'b0);
        end
      end else if (!pad_seen) begin
        if (v == PAD_CHAR) begin
          pad_seen = 1'b1;
        end else begin
          c           = code_of(v);
          bad_now     = (c == BAD_CODE);
          carried_bad = (held == BAD_CODE);
          case (group_pos)
            GRP_P0: begin
              held      = c;
              group_pos = GRP_P1;
            end
            GRP_P1: begin
              emit({held[5:0], c[5:4]}, 1'b1, bad_now | carried_bad);
              held      = c;
              group_pos = GRP_P2;
            end
            GRP_P2: begin
              emit({held[3:0], c[5:2]}, 1'b1, bad_now | carried_bad);
              held      = c;
              group_pos = GRP_P3;
            end
            default: begin
              // a bad code keeps all its bits here
              emit({held[1:0], 6'h00} | c, 1'b1, bad_now | carried_bad);
              held      = 8'h00;
              group_pos = GRP_P0;
            end
          endcase
        end
      end
      if (last) begin
        if (step_n == 0) emit(8'h00, 1'b0, bad_now);
        step_res[step_n-1].end_of_run = 1'b1;
        restart(dir);
      end
      for (int i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
    endfunction

    function void check_result(logic [7:0] val, logic has, logic eor, logic bad);
      codec_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%h has_data=%b end_of_run=%b bad_char=%b",
                 $time, val, has, eor, bad);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (val !== want.value) begin
        $display("%0t: out_value expected %h actual %h", $time, want.value, val);
        errors++;
      end
      if (has !== want.has_data) begin
        $display("%0t: has_data expected %b actual %b", $time, want.has_data, has);
        errors++;
      end
      if (eor !== want.end_of_run) begin
        $display("%0t: end_of_run expected %b actual %b", $time, want.end_of_run, eor);
        errors++;
      end
      if (bad !== want.bad_char) begin
        $display("%0t: bad_char expected %b actual %b", $time, want.bad_char, bad);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_value_i  = 8'h00;
  logic       last_item_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_value_o;
  logic       has_data_o;
  logic       end_of_run_o;
  logic       bad_char_o;

  codec_scoreboard sb = new();
  int cycles      = 0;
  int burst_left  = 0;
  int hold_cycles = 0;
  bit steady      = 1'b0;

  base64_stream_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_value_i  (in_value_i),
    .last_item_i (last_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .has_data_o  (has_data_o),
    .end_of_run_o(end_of_run_o),
    .bad_char_o  (bad_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_base64_stream_codec NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_item(in_value_i, last_item_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_value_o, has_data_o, end_of_run_o, bad_char_o);
    end
  end

  // receiver: switches between stall patterns, long hold-off on request
  initial begin
    int pat_mode;
    int pat_left;
    pat_mode = 0;
    pat_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ((pat_left % 4) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_msg(input byte_q_t msg, input bit close);
    int gap;
    foreach (msg[i]) begin
      if (burst_left == 0) begin
        if (steady) gap = 0;
        else if ($urandom_range(0, 4) == 0) gap = $urandom_range(4, 20);
        else gap = $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 16);
      end
      in_valid_i  <= 1'b1;
      in_value_i  <= msg[i];
      last_item_i <= close && (i == msg.size() - 1);
      do @(posedge clk_i); while (in_ready_o !== 1'b1);
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    byte_q_t msg;
    msg = {};
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    send_msg(msg, 1'b1);
  endtask

  // sender pauses until every owed result is out and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.restart(d);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic d, input bit squeeze);
    byte_q_t    msg;
    int         budget;
    int         len;
    int         npad;
    logic [7:0] ch;
    set_direction(d);
    budget = PHASE_ITEMS;
    if (squeeze) begin
      steady      = 1'b1;
      hold_cycles = 250;
    end
    while (budget > 0) begin
      msg = {};
      if (d == DIR_ENCODE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 4) != 0) begin
        // mostly well-formed text with random content
        len = $urandom_range(1, 12);
        repeat (len) msg.push_back(sb.alphabet[$urandom_range(0, 63)]);
        if ($urandom_range(0, 5) == 0) begin
          do ch = 8'($urandom_range(0, 255));
          while (sb.code_of(ch) != BAD_CODE || ch == PAD_CHAR);
          msg[$urandom_range(0, len - 1)] = ch;
        end
        npad = (len % 4 == 2) ? 2 : (len % 4 == 3) ? 1 : 0;
        if ($urandom_range(0, 5) == 0) npad = $urandom_range(0, 3);
        repeat (npad) msg.push_back(PAD_CHAR);
        if (npad > 0 && $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      end
      // the closing message of a phase is sometimes cut short by the direction write
      send_msg(msg, budget > msg.size() || $urandom_range(0, 3) != 0);
      budget -= msg.size();
    end
    drain();
    steady = 1'b0;
  endtask

  initial begin
    byte_q_t msg;
    logic    d;
    sb.restart(DIR_ENCODE);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encode: one-byte and two-byte flushes, then a full group
    msg = {8'h00};
    send_msg(msg, 1'b1);
    msg = {8'hff, 8'hff};
    send_msg(msg, 1'b1);
    send_text("Man");
    drain();

    set_direction(DIR_DECODE);
    send_text("QQ==");
    send_text("+/A*");
    send_text("*BC");   // bad char flag carried to the next byte
    send_text("#");     // lone bad char ends the message
    send_text("Q");     // lone trailing char gives no byte
    send_text("QQ=Z");  // chars after padding are ignored
    send_text("*=");    // padding drops the pending flag
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      d = (p < 4) ? 1'(p % 2) : 1'($urandom_range(0, 1));
      run_phase(d, p == SQUEEZE_PHASE);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_base64_stream_codec OK");
    end else begin
      $display("tb_base64_stream_codec NOT OK");
    end
    $finish;
  end

endmodule
